### hw/rtl/bkem_pkg.sv
// Package with the control word format, codes and microprogram of the key event mapper.
`timescale 1ns / 1ps
`default_nettype none

package bkem_pkg;

  // Default sizes.
  localparam int SLOTS_DEF       = 16;
  localparam int MACRO_COUNT_DEF = 16;

  // Fixed field widths.
  localparam int SLOT_W  = 4;
  localparam int BYTE_W  = 8;
  localparam int EV_W    = 2;
  localparam int CNT_OUT_W = 5;
  localparam int MAX_RESULTS = 16;

  // Event codes.
  localparam logic [EV_W-1:0] EV_NONE    = 2'd0;
  localparam logic [EV_W-1:0] EV_PRESS   = 2'd1;
  localparam logic [EV_W-1:0] EV_RELEASE = 2'd2;
  localparam logic [EV_W-1:0] EV_MACRO   = 2'd3;

  // Datapath operations.
  localparam int OP_W = 4;
  localparam logic [OP_W-1:0] OP_NOP      = 4'd0;
  localparam logic [OP_W-1:0] OP_ACCEPT   = 4'd1;
  localparam logic [OP_W-1:0] OP_SAVEPREV = 4'd2;
  localparam logic [OP_W-1:0] OP_DROP_UPD = 4'd3;
  localparam logic [OP_W-1:0] OP_MACRO    = 4'd4;
  localparam logic [OP_W-1:0] OP_PRESS    = 4'd5;
  localparam logic [OP_W-1:0] OP_FINISH   = 4'd6;
  localparam logic [OP_W-1:0] OP_DROP_ALL = 4'd7;
  localparam logic [OP_W-1:0] OP_ADV      = 4'd8;
  localparam logic [OP_W-1:0] OP_CLRPREV  = 4'd9;

  // Jump conditions.
  localparam int COND_W = 3;
  localparam logic [COND_W-1:0] C_NEVER    = 3'd0;
  localparam logic [COND_W-1:0] C_ALWAYS   = 3'd1;
  localparam logic [COND_W-1:0] C_NO_ITEM  = 3'd2;
  localparam logic [COND_W-1:0] C_CMD      = 3'd3;
  localparam logic [COND_W-1:0] C_OOR      = 3'd4;
  localparam logic [COND_W-1:0] C_DIS_MAC  = 3'd5;
  localparam logic [COND_W-1:0] C_LAST_IDX = 3'd6;

  // Program addresses.
  localparam int PC_W = 4;
  localparam logic [PC_W-1:0] PC_IDLE    = 4'd0;
  localparam logic [PC_W-1:0] PC_DISP    = 4'd1;
  localparam logic [PC_W-1:0] PC_CHK     = 4'd2;
  localparam logic [PC_W-1:0] PC_DROP    = 4'd3;
  localparam logic [PC_W-1:0] PC_MAC     = 4'd4;
  localparam logic [PC_W-1:0] PC_PRESS   = 4'd5;
  localparam logic [PC_W-1:0] PC_FIN     = 4'd6;
  localparam logic [PC_W-1:0] PC_RA_WAIT = 4'd7;
  localparam logic [PC_W-1:0] PC_RA_DROP = 4'd8;
  localparam logic [PC_W-1:0] PC_RA_ADV  = 4'd9;
  localparam logic [PC_W-1:0] PC_RA_END  = 4'd10;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [COND_W-1:0] cond;
    logic [PC_W-1:0]   target;
  } ctrl_t;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    logic no_item;
    logic cmd;
    logic oor;
    logic dis_mac;
    logic last_idx;
    logic stall;
  } stat_t;

  // The microprogram. Each step runs its operation, then, unless stalled, jumps to target if
  // the condition holds, else falls through to the next step.
  function automatic ctrl_t ucode_word(input logic [PC_W-1:0] pc);
    ctrl_t w;
    case (pc)
      PC_IDLE:    w = '{op: OP_ACCEPT,   cond: C_NO_ITEM,  target: PC_IDLE};
      PC_DISP:    w = '{op: OP_NOP,      cond: C_CMD,      target: PC_RA_WAIT};
      PC_CHK:     w = '{op: OP_SAVEPREV, cond: C_OOR,      target: PC_FIN};
      PC_DROP:    w = '{op: OP_DROP_UPD, cond: C_NEVER,    target: PC_IDLE};
      PC_MAC:     w = '{op: OP_MACRO,    cond: C_DIS_MAC,  target: PC_FIN};
      PC_PRESS:   w = '{op: OP_PRESS,    cond: C_NEVER,    target: PC_IDLE};
      PC_FIN:     w = '{op: OP_FINISH,   cond: C_ALWAYS,   target: PC_IDLE};
      PC_RA_WAIT: w = '{op: OP_NOP,      cond: C_NEVER,    target: PC_IDLE};
      PC_RA_DROP: w = '{op: OP_DROP_ALL, cond: C_LAST_IDX, target: PC_RA_END};
      PC_RA_ADV:  w = '{op: OP_ADV,      cond: C_ALWAYS,   target: PC_RA_WAIT};
      PC_RA_END:  w = '{op: OP_CLRPREV,  cond: C_ALWAYS,   target: PC_FIN};
      default:    w = '{op: OP_NOP,      cond: C_ALWAYS,   target: PC_IDLE};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/bkem_sequencer.sv
// Step counter and control store of the key event mapper.
`timescale 1ns / 1ps
`default_nettype none

module bkem_sequencer (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire bkem_pkg::stat_t stat,
  output bkem_pkg::ctrl_t     ctrl
);
  import bkem_pkg::*;

  logic [PC_W-1:0] pc_r;
  logic [PC_W-1:0] pc_nxt;
  logic            take;

  assign ctrl = ucode_word(pc_r);

  always_comb begin
    case (ctrl.cond)
      C_NEVER:    take = 1'b0;
      C_ALWAYS:   take = 1'b1;
      C_NO_ITEM:  take = stat.no_item;
      C_CMD:      take = stat.cmd;
      C_OOR:      take = stat.oor;
      C_DIS_MAC:  take = stat.dis_mac;
      C_LAST_IDX: take = stat.last_idx;
      default:    take = 1'b1;
    endcase
    if (stat.stall) begin
      pc_nxt = pc_r;
    end else if (take) begin
      pc_nxt = ctrl.target;
    end else begin
      pc_nxt = pc_r + PC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= PC_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  // The step counter only leaves idle through an accepted request.
  a_idle_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (pc_r == PC_IDLE && stat.no_item) |=> (pc_r == PC_IDLE))
    else $error("sequencer left idle without a request");
  // A stalled step holds the step counter.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    stat.stall |=> (pc_r == $past(pc_r)))
    else $error("step counter moved during a stall");
`endif

endmodule

`default_nettype wire

### hw/rtl/bkem_datapath.sv
// Slot state, key memory, event staging and output register of the key event mapper.
`timescale 1ns / 1ps
`default_nettype none

module bkem_datapath #(
  parameter int SLOTS       = bkem_pkg::SLOTS_DEF,
  parameter int MACRO_COUNT = bkem_pkg::MACRO_COUNT_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire bkem_pkg::ctrl_t               ctrl,
  output bkem_pkg::stat_t                    stat,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          in_command,
  input  wire logic [bkem_pkg::SLOT_W-1:0]   in_slot,
  input  wire logic                          in_pressed,
  input  wire logic                          in_enabled,
  input  wire logic                          in_has_macro,
  input  wire logic [bkem_pkg::BYTE_W-1:0]   in_macro_number,
  input  wire logic [bkem_pkg::BYTE_W-1:0]   in_keycode,
  input  wire logic [bkem_pkg::BYTE_W-1:0]   in_modifiers,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [bkem_pkg::EV_W-1:0]          out_event_res,
  output logic [bkem_pkg::BYTE_W-1:0]        out_event_key,
  output logic [bkem_pkg::BYTE_W-1:0]        out_event_mods,
  output logic [bkem_pkg::BYTE_W-1:0]        out_event_macro,
  output logic [bkem_pkg::CNT_OUT_W-1:0]     out_active_count,
  output logic                               out_last
);
  import bkem_pkg::*;

  localparam int IW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNTW = $clog2(SLOTS + 1);
  localparam int SW   = ((IW > SLOT_W) ? IW : SLOT_W) + 1;
  localparam int NW   = $clog2(MAX_RESULTS + 1) + 1;

  // Captured request.
  logic              cmd_r, in_range_r, pressed_r, en_r, mac_ok_r;
  logic [BYTE_W-1:0] mac_r, key_r, mods_r;

  // Slot state.
  logic [SLOTS-1:0]  active_r;
  logic [SLOTS-1:0]  prev_vec_r;
  logic              prev_old_r;
  logic [CNTW-1:0]   cnt_r;
  logic [IW-1:0]     idx_r;
  logic [NW-1:0]     n_r;

  // Held key and modifiers, one entry per slot.
  logic [BYTE_W-1:0] key_mem [SLOTS];
  logic [BYTE_W-1:0] mods_mem [SLOTS];
  logic [BYTE_W-1:0] rd_key_r, rd_mods_r;
  logic              mem_we;

  // Staged event and output register.
  logic                 pend_v_r;
  logic [EV_W-1:0]      pend_ev_r;
  logic [BYTE_W-1:0]    pend_key_r, pend_mods_r, pend_mac_r;
  logic [CNT_OUT_W-1:0] pend_cnt_r;
  logic                 out_valid_r, out_last_r;
  logic [EV_W-1:0]      out_ev_r;
  logic [BYTE_W-1:0]    out_key_r, out_mods_r, out_mac_r;
  logic [CNT_OUT_W-1:0] out_cnt_r;

  logic              in_acc, act, mism, drop_req;
  logic              emit_want, emit_free, out_free, do_emit, out_load;
  logic [EV_W-1:0]   ev_code;
  logic [BYTE_W-1:0] ev_key, ev_mods, ev_mac;
  logic [CNTW-1:0]   ev_cnt;
  logic [CNTW+CNT_OUT_W-1:0] ev_cnt_ext;
  logic [SW-1:0]     slot_ext;

  assign in_ready  = (ctrl.op == OP_ACCEPT);
  assign in_acc    = in_valid && in_ready;
  assign slot_ext  = SW'(in_slot);

  assign act       = active_r[idx_r];
  assign mism      = (rd_key_r != key_r) || (rd_mods_r != mods_r);
  assign drop_req  = !en_r || mac_ok_r || !pressed_r || mism;
  assign out_free  = !out_valid_r || out_ready;
  assign emit_free = !pend_v_r || out_free;

  always_comb begin
    emit_want = 1'b0;
    ev_code   = EV_NONE;
    ev_key    = '0;
    ev_mods   = '0;
    ev_mac    = '0;
    ev_cnt    = cnt_r;
    mem_we    = 1'b0;
    case (ctrl.op)
      OP_DROP_UPD, OP_DROP_ALL: begin
        if (ctrl.op == OP_DROP_UPD) begin
          emit_want = act && drop_req;
        end else begin
          emit_want = act && (n_r < NW'(MAX_RESULTS));
        end
        ev_code = EV_RELEASE;
        ev_key  = rd_key_r;
        ev_mods = rd_mods_r;
        ev_cnt  = cnt_r - CNTW'(1);
      end
      OP_MACRO: begin
        emit_want = en_r && mac_ok_r && pressed_r && !prev_old_r;
        ev_code   = EV_MACRO;
        ev_mac    = mac_r;
      end
      OP_PRESS: begin
        emit_want = pressed_r && !act && (key_r != '0);
        ev_code   = EV_PRESS;
        ev_key    = key_r;
        ev_mods   = mods_r;
        ev_cnt    = cnt_r + CNTW'(1);
        mem_we    = emit_want && emit_free;
      end
      default: begin
        emit_want = 1'b0;
      end
    endcase
  end

  assign do_emit    = emit_want && emit_free;
  assign ev_cnt_ext = {{CNT_OUT_W{1'b0}}, ev_cnt};
  // The output register loads either at the end of a request or when a new
  // event pushes the staged one out.
  assign out_load   = ((ctrl.op == OP_FINISH) && out_free) || (do_emit && pend_v_r);

  always_comb begin
    stat.no_item  = !in_acc;
    stat.cmd      = cmd_r;
    stat.oor      = !in_range_r;
    stat.dis_mac  = !en_r || mac_ok_r;
    stat.last_idx = (idx_r == IW'(SLOTS - 1));
    stat.stall    = (emit_want && !emit_free) || ((ctrl.op == OP_FINISH) && !out_free);
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      key_mem[idx_r]  <= key_r;
      mods_mem[idx_r] <= mods_r;
    end
    rd_key_r  <= key_mem[idx_r];
    rd_mods_r <= mods_mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= '0;
      prev_vec_r  <= '0;
      cnt_r       <= '0;
      n_r         <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (ctrl.op)
        OP_ACCEPT: begin
          if (in_acc) begin
            cmd_r      <= in_command;
            in_range_r <= (slot_ext < SW'(SLOTS));
            pressed_r  <= in_pressed;
            en_r       <= in_enabled;
            mac_ok_r   <= in_has_macro && ({1'b0, in_macro_number} < 9'(MACRO_COUNT));
            mac_r      <= in_macro_number;
            key_r      <= in_keycode;
            mods_r     <= in_modifiers;
            idx_r      <= in_command ? '0 : slot_ext[IW-1:0];
            n_r        <= '0;
          end
        end
        OP_SAVEPREV: begin
          if (in_range_r) begin
            prev_old_r        <= prev_vec_r[idx_r];
            prev_vec_r[idx_r] <= pressed_r;
          end
        end
        OP_DROP_UPD, OP_DROP_ALL: begin
          if (do_emit) begin
            active_r[idx_r] <= 1'b0;
            cnt_r           <= ev_cnt;
          end
        end
        OP_PRESS: begin
          if (do_emit) begin
            active_r[idx_r] <= 1'b1;
            cnt_r           <= ev_cnt;
          end
        end
        OP_FINISH: begin
          if (out_free) begin
            out_last_r  <= 1'b1;
            pend_v_r    <= 1'b0;
            if (pend_v_r) begin
              out_ev_r   <= pend_ev_r;
              out_key_r  <= pend_key_r;
              out_mods_r <= pend_mods_r;
              out_mac_r  <= pend_mac_r;
              out_cnt_r  <= pend_cnt_r;
            end else begin
              out_ev_r   <= EV_NONE;
              out_key_r  <= '0;
              out_mods_r <= '0;
              out_mac_r  <= '0;
              out_cnt_r  <= ev_cnt_ext[CNT_OUT_W-1:0];
            end
          end
        end
        OP_ADV: begin
          idx_r <= idx_r + IW'(1);
        end
        OP_CLRPREV: begin
          prev_vec_r <= '0;
        end
        default: begin
        end
      endcase

      // An event waits in the staging register until the next one, or the
      // end of the request, tells whether it is the final result.
      if (do_emit) begin
        if (pend_v_r) begin
          out_last_r  <= 1'b0;
          out_ev_r    <= pend_ev_r;
          out_key_r   <= pend_key_r;
          out_mods_r  <= pend_mods_r;
          out_mac_r   <= pend_mac_r;
          out_cnt_r   <= pend_cnt_r;
        end
        pend_v_r    <= 1'b1;
        pend_ev_r   <= ev_code;
        pend_key_r  <= ev_key;
        pend_mods_r <= ev_mods;
        pend_mac_r  <= ev_mac;
        pend_cnt_r  <= ev_cnt_ext[CNT_OUT_W-1:0];
        n_r         <= n_r + NW'(1);
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_event_res    = out_ev_r;
  assign out_event_key    = out_key_r;
  assign out_event_mods   = out_mods_r;
  assign out_event_macro  = out_mac_r;
  assign out_active_count = out_cnt_r;
  assign out_last         = out_last_r;

`ifndef NO_ASSERTIONS
  // The live count always matches the number of active slots.
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(active_r) == int'(cnt_r))
    else $error("active count out of step with slot flags");
  // No event is left staged when a new request is taken.
  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.op == OP_ACCEPT) |-> !pend_v_r)
    else $error("staged event left over at idle");
  // A release-all never emits more than the result limit.
  a_limit: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= NW'(MAX_RESULTS))
    else $error("too many results for one request");
`endif

endmodule

`default_nettype wire

### hw/rtl/button_to_key_event_mapper_unit.sv
// Top level of the button to key event mapper: stream ports around sequencer and datapath.
// An update request runs the dispatch, check, drop, macro, press and finish steps; a disabled
// or macro slot skips press, a slot out of range skips to finish, and out_tready can stall.
// A release-all reads the memory for each slot, decides, and advances until the last slot.
// Throughput: one request at a time; the next is taken the cycle after the final result loads.
// Reset: synchronous active-low rst_n clears all slot flags, counts and handshakes at once;
// the key memory needs no clearing since it is read only for slots that hold a key.
`timescale 1ns / 1ps
`default_nettype none

module button_to_key_event_mapper_unit #(
  parameter int SLOTS       = bkem_pkg::SLOTS_DEF,
  parameter int MACRO_COUNT = bkem_pkg::MACRO_COUNT_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // slot[3:0], pressed[4], enabled[5], has_macro[6], macro_number[14:7],
  // keycode[22:15], modifiers[30:23], zero[31]
  input  wire logic [31:0] in_tdata,
  // command[0]
  input  wire logic        in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // event_key[7:0], event_mods[15:8], event_macro[23:16], active_count[28:24],
  // zero[31:29]
  output logic [31:0]      out_tdata,
  // event_res[1:0]
  output logic [1:0]       out_tuser,
  output logic             out_tlast
);
  import bkem_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  logic [BYTE_W-1:0]    ev_key, ev_mods, ev_mac;
  logic [CNT_OUT_W-1:0] ev_cnt;

  // The sequencer steps through one control word per cycle unless the datapath signals a stall.
  bkem_sequencer u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  // The datapath holds slot state and the result registers.
  bkem_datapath #(
    .SLOTS       (SLOTS),
    .MACRO_COUNT (MACRO_COUNT)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .ctrl             (ctrl),
    .stat             (stat),
    .in_valid         (in_tvalid),
    .in_ready         (in_tready),
    .in_command       (in_tuser),
    .in_slot          (in_tdata[3:0]),
    .in_pressed       (in_tdata[4]),
    .in_enabled       (in_tdata[5]),
    .in_has_macro     (in_tdata[6]),
    .in_macro_number  (in_tdata[14:7]),
    .in_keycode       (in_tdata[22:15]),
    .in_modifiers     (in_tdata[30:23]),
    .out_valid        (out_tvalid),
    .out_ready        (out_tready),
    .out_event_res    (out_tuser),
    .out_event_key    (ev_key),
    .out_event_mods   (ev_mods),
    .out_event_macro  (ev_mac),
    .out_active_count (ev_cnt),
    .out_last         (out_tlast)
  );

  // Pack the result fields, lowest field in the lowest bits.
  assign out_tdata = {3'b000, ev_cnt, ev_mac, ev_mods, ev_key};

endmodule

`default_nettype wire
